@@ design/rhc_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB/HSV converter package
// Beat types, fixed-point constants and small helpers shared by the design.
// ----------------------------------------------------------------------------
package rhc_pkg;

  typedef struct packed {
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [12:0] saturation;
    logic [12:0] brightness;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [14:0] out_hue;
    logic [12:0] out_saturation;
    logic [12:0] out_brightness;
  } out_t;

  localparam logic        KIND_TO_HSV = 1'b0;
  localparam logic        KIND_TO_RGB = 1'b1;

  localparam logic [14:0] HUE_FULL   = 15'd23040;
  localparam logic [11:0] HUE_SECTOR = 12'd3840;
  localparam logic [12:0] UNIT       = 13'd4096;
  localparam logic [23:0] WHOLE      = 24'd15728640;

  // Divider geometry: 24-bit dividend, 8-bit divisor, 16 quotient bits.
  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned DIV_STEPS  = 4;

  // floor(y / 255) for y below 4096, by multiplying with the reciprocal.
  function automatic logic [4:0] div255(input logic [11:0] y);
    logic [20:0] prod;
    prod = ({9'd0, y} + 21'd1) * 21'd257;
    return prod[20:16];
  endfunction

endpackage

@@ design/rhc_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Four register stages, four quotient bits per stage, no stall.
// ----------------------------------------------------------------------------
module rhc_div (
  input  logic        clk_i,
  input  logic [23:0] dividend_i,
  input  logic [7:0]  divisor_i,
  output logic [15:0] quotient_o
);
  import rhc_pkg::*;

  // The upper dividend byte must be below the divisor so the quotient fits.
  logic [7:0]  rem_q  [DIV_STAGES];
  logic [15:0] low_q  [DIV_STAGES];
  logic [7:0]  dvs_q  [DIV_STAGES];
  logic [15:0] quo_q  [DIV_STAGES];

  logic [7:0]  rem_d  [DIV_STAGES];
  logic [15:0] low_d  [DIV_STAGES];
  logic [7:0]  dvs_d  [DIV_STAGES];
  logic [15:0] quo_d  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [7:0]  rem_in;
    logic [15:0] low_in;
    logic [7:0]  dvs_in;
    logic [15:0] quo_in;

    if (k == 0) begin : g_first
      assign rem_in = dividend_i[23:16];
      assign low_in = dividend_i[15:0];
      assign dvs_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [8:0]  r9;
      logic [7:0]  r;
      logic [15:0] lo;
      logic [15:0] qu;
      r  = rem_in;
      lo = low_in;
      qu = quo_in;
      for (int i = 0; i < DIV_STEPS; i++) begin
        r9 = {r, lo[15]};
        lo = {lo[14:0], 1'b0};
        if (r9 >= {1'b0, dvs_in}) begin
          r9 = r9 - {1'b0, dvs_in};
          qu = {qu[14:0], 1'b1};
        end else begin
          qu = {qu[14:0], 1'b0};
        end
        r = r9[7:0];
      end
      rem_d[k] = r;
      low_d[k] = lo;
      dvs_d[k] = dvs_in;
      quo_d[k] = qu;
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d[k];
      low_q[k] <= low_d[k];
      dvs_q[k] <= dvs_d[k];
      quo_q[k] <= quo_d[k];
    end
  end

  assign quotient_o = quo_q[DIV_STAGES-1];

endmodule

@@ design/rgb_hsv_color_converter.sv @@
// ----------------------------------------------------------------------------
// RGB/HSV color converter
// A beat accepted at a clock edge moves through every pipeline stage and appears
// on result_o, marked by result_valid_o, for one cycle.
// Throughput: one beat per cycle; busy is always low since the result side
// cannot stall and nothing carries over between pixels.
// Reset clears only the valid bits of the six pipeline stages.
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  rhc_pkg::in_t cmd_i,
  output logic         result_valid_o,
  output rhc_pkg::out_t result_o
);
  import rhc_pkg::*;

  // Stage valid and direction bits travel with the data.
  logic [5:0] vld_q;
  logic [5:0] kind_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= {kind_q[4:0], cmd_i.kind};
  end

  // --------------------------------------------------------------------------
  // Stage 1. RGB side: max, min, spread and the sector-relative hue numerator
  // in units of the spread. HSV side: clamp, wrap the hue once and find the
  // sector and its fractional offset.
  // --------------------------------------------------------------------------
  logic [7:0]  mx_d, mn_d, dl_d;
  logic [10:0] m_d;
  logic [12:0] s_d, v_d;
  logic [2:0]  sec_d;
  logic [11:0] f_d;

  always_comb begin
    logic [11:0] mm;
    logic [14:0] h;
    mx_d = cmd_i.red;
    if (cmd_i.green > mx_d) mx_d = cmd_i.green;
    if (cmd_i.blue > mx_d) mx_d = cmd_i.blue;
    mn_d = cmd_i.red;
    if (cmd_i.green < mn_d) mn_d = cmd_i.green;
    if (cmd_i.blue < mn_d) mn_d = cmd_i.blue;
    dl_d = mx_d - mn_d;

    // Red wins a tie for the largest channel, then green.
    if (mx_d == cmd_i.red) begin
      mm = {4'd0, cmd_i.green} - {4'd0, cmd_i.blue};
    end else if (mx_d == cmd_i.green) begin
      mm = {3'd0, dl_d, 1'b0} + {4'd0, cmd_i.blue} - {4'd0, cmd_i.red};
    end else begin
      mm = {2'd0, dl_d, 2'b0} + {4'd0, cmd_i.red} - {4'd0, cmd_i.green};
    end
    // A negative numerator moves up by one full turn of six sectors.
    if (mm[11]) begin
      mm = mm + {3'd0, dl_d, 1'b0} + {2'd0, dl_d, 2'b0};
    end
    m_d = mm[10:0];

    s_d = (cmd_i.saturation > UNIT) ? UNIT : cmd_i.saturation;
    v_d = (cmd_i.brightness > UNIT) ? UNIT : cmd_i.brightness;
    h   = (cmd_i.hue >= HUE_FULL) ? cmd_i.hue - HUE_FULL : cmd_i.hue;

    if (h < 15'd3840) begin
      sec_d = 3'd0;
      f_d   = h[11:0];
    end else if (h < 15'd7680) begin
      sec_d = 3'd1;
      f_d   = 12'(h - 15'd3840);
    end else if (h < 15'd11520) begin
      sec_d = 3'd2;
      f_d   = 12'(h - 15'd7680);
    end else if (h < 15'd15360) begin
      sec_d = 3'd3;
      f_d   = 12'(h - 15'd11520);
    end else if (h < 15'd19200) begin
      sec_d = 3'd4;
      f_d   = 12'(h - 15'd15360);
    end else begin
      sec_d = 3'd5;
      f_d   = 12'(h - 15'd19200);
    end
  end

  logic [7:0]  mx1_q, dl1_q;
  logic [10:0] m1_q;
  logic [12:0] s1_q, v1_q;
  logic [2:0]  sec1_q;
  logic [11:0] f1_q;

  always_ff @(posedge clk_i) begin
    mx1_q  <= mx_d;
    dl1_q  <= dl_d;
    m1_q   <= m_d;
    s1_q   <= s_d;
    v1_q   <= v_d;
    sec1_q <= sec_d;
    f1_q   <= f_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2. RGB side: scale the hue numerator by one sector, build the
  // saturation dividend and the value. HSV side: saturation times offsets.
  // --------------------------------------------------------------------------
  logic [22:0] n2_q;
  logic [19:0] ds2_q;
  logic [7:0]  mx2_q, dl2_q;
  logic [12:0] val2_q;
  logic [24:0] sf2_q, sg2_q;
  logic [12:0] sinv2_q, v2_q;
  logic [2:0]  sec2_q;
  logic        grey2_q;

  always_ff @(posedge clk_i) begin
    n2_q    <= 23'(m1_q) * 23'(HUE_SECTOR);
    ds2_q   <= {dl1_q, 12'd0};
    mx2_q   <= mx1_q;
    dl2_q   <= dl1_q;
    val2_q  <= {1'b0, mx1_q, 4'd0} + 13'(div255({mx1_q, 4'd0}));
    sf2_q   <= 25'(s1_q) * 25'(f1_q);
    sg2_q   <= 25'(s1_q) * 25'(HUE_SECTOR - f1_q);
    sinv2_q <= UNIT - s1_q;
    v2_q    <= v1_q;
    sec2_q  <= sec1_q;
    grey2_q <= (s1_q == '0);
  end

  // --------------------------------------------------------------------------
  // Stages 3 to 6, RGB side: hue and saturation come out of two pipelined
  // dividers; value and the zero-spread flag ride alongside.
  // --------------------------------------------------------------------------
  logic [15:0] hue_quo, sat_quo;

  rhc_div u_hue_div (
    .clk_i      (clk_i),
    .dividend_i ({1'b0, n2_q}),
    .divisor_i  (dl2_q),
    .quotient_o (hue_quo)
  );

  rhc_div u_sat_div (
    .clk_i      (clk_i),
    .dividend_i ({4'd0, ds2_q}),
    .divisor_i  (mx2_q),
    .quotient_o (sat_quo)
  );

  logic [12:0] val_q [4];
  logic [3:0]  flat_q;

  always_ff @(posedge clk_i) begin
    val_q[0] <= val2_q;
    val_q[1] <= val_q[0];
    val_q[2] <= val_q[1];
    val_q[3] <= val_q[2];
    flat_q   <= {flat_q[2:0], (dl2_q == '0)};
  end

  // --------------------------------------------------------------------------
  // Stages 3 to 6, HSV side. The product v * X * 255 / (4096^2 * 3840)
  // reduces to v * X * 17 / 2^32 because 255 = 17 * 15 and 3840 = 256 * 15.
  // --------------------------------------------------------------------------
  logic [23:0] x3_q, y3_q;
  logic [12:0] sinv3_q, v3_q;
  logic [2:0]  sec3_q;
  logic        grey3_q;

  always_ff @(posedge clk_i) begin
    x3_q    <= WHOLE - sf2_q[23:0];
    y3_q    <= WHOLE - sg2_q[23:0];
    sinv3_q <= sinv2_q;
    v3_q    <= v2_q;
    sec3_q  <= sec2_q;
    grey3_q <= grey2_q;
  end

  logic [35:0] vx4_q, vy4_q;
  logic [25:0] vp4_q;
  logic [12:0] v4_q;
  logic [2:0]  sec4_q;
  logic        grey4_q;

  always_ff @(posedge clk_i) begin
    vx4_q   <= 36'(v3_q) * 36'(x3_q);
    vy4_q   <= 36'(v3_q) * 36'(y3_q);
    vp4_q   <= 26'(v3_q) * 26'(sinv3_q);
    v4_q    <= v3_q;
    sec4_q  <= sec3_q;
    grey4_q <= grey3_q;
  end

  logic [7:0] r5_d, g5_d, b5_d;

  always_comb begin
    logic [40:0] qx, tx;
    logic [33:0] px;
    logic [20:0] tpx;
    logic [7:0]  q8, t8, p8, top8;
    qx   = {vx4_q, 4'd0} + 41'(vx4_q);
    tx   = {vy4_q, 4'd0} + 41'(vy4_q);
    px   = {vp4_q, 8'd0} - 34'(vp4_q);
    tpx  = {v4_q, 8'd0} - 21'(v4_q);
    q8   = qx[39:32];
    t8   = tx[39:32];
    p8   = px[31:24];
    top8 = tpx[19:12];
    if (grey4_q) begin
      r5_d = top8;
      g5_d = top8;
      b5_d = top8;
    end else begin
      case (sec4_q)
        3'd0: begin r5_d = top8; g5_d = t8;   b5_d = p8;   end
        3'd1: begin r5_d = q8;   g5_d = top8; b5_d = p8;   end
        3'd2: begin r5_d = p8;   g5_d = top8; b5_d = t8;   end
        3'd3: begin r5_d = p8;   g5_d = q8;   b5_d = top8; end
        3'd4: begin r5_d = t8;   g5_d = p8;   b5_d = top8; end
        default: begin r5_d = top8; g5_d = p8; b5_d = q8; end
      endcase
    end
  end

  logic [7:0] r5_q, g5_q, b5_q;
  logic [7:0] r6_q, g6_q, b6_q;

  always_ff @(posedge clk_i) begin
    r5_q <= r5_d;
    g5_q <= g5_d;
    b5_q <= b5_d;
    r6_q <= r5_q;
    g6_q <= g5_q;
    b6_q <= b5_q;
  end

  // --------------------------------------------------------------------------
  // Output beat: the unused half of the result is zero.
  // --------------------------------------------------------------------------
  assign result_valid_o = vld_q[5];

  always_comb begin
    result_o = '0;
    if (kind_q[5] == KIND_TO_RGB) begin
      result_o.out_red   = r6_q;
      result_o.out_green = g6_q;
      result_o.out_blue  = b6_q;
    end else begin
      result_o.out_brightness = val_q[3];
      if (!flat_q[3]) begin
        result_o.out_hue        = hue_quo[14:0];
        result_o.out_saturation = sat_quo[12:0];
      end
    end
  end

endmodule

@@ tb/rgb_hsv_color_converter_tb.sv @@
// ----------------------------------------------------------------------------
// RGB/HSV color converter testbench
// Drives directed and random pixel beats in both directions with random
// gaps, predicts every result in exact integer arithmetic and compares each
// result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rgb_hsv_color_converter_tb;
  import rhc_pkg::*;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  in_t   cmd_i = '0;
  logic  result_valid_o;
  out_t  result_o;

  // Beats waiting to be driven, and predicted results waiting to arrive.
  in_t   pending_pixels[$];
  out_t  predicted_pixels[$];
  int    error_count = 0;
  bit    stimulus_done = 1'b0;
  int    beat_index = 0;

  always #4 clk_i = ~clk_i;

  rgb_hsv_color_converter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // Exact conversion of one pixel, all products done in 64 bits so that
  // nothing is rounded before the final truncating division.
  function automatic out_t convert_pixel(input in_t px);
    out_t res;
    longint unsigned r, g, b, mx, mn, d, h, s, v, top, sec, f, den, whole;
    longint unsigned p, q, t, r8, g8, b8, nu;
    longint base, num, n;
    res = '0;
    if (px.kind == KIND_TO_HSV) begin
      r = px.red; g = px.green; b = px.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      res.out_brightness = 13'((mx * 4096) / 255);
      if (d != 0) begin
        res.out_saturation = 13'((d * 4096) / mx);
        // Ties go to red first, then green.
        if (mx == r) begin
          base = 0; num = longint'(g) - longint'(b);
        end else if (mx == g) begin
          base = 2; num = longint'(b) - longint'(r);
        end else begin
          base = 4; num = longint'(r) - longint'(g);
        end
        n = 3840 * (base * longint'(d) + num);
        if (n < 0) n += 23040 * longint'(d);
        nu = n;
        res.out_hue = 15'(nu / d);
      end
    end else begin
      h = px.hue;
      s = (px.saturation > 4096) ? 4096 : px.saturation;
      v = (px.brightness > 4096) ? 4096 : px.brightness;
      top = (v * 255) / 4096;
      if (s == 0) begin
        r8 = top; g8 = top; b8 = top;
      end else begin
        // The wrap is applied once only.
        if (h >= 23040) h -= 23040;
        sec = h / 3840;
        f = h - sec * 3840;
        den = 64'd4096 * 4096 * 3840;
        whole = 64'd4096 * 3840;
        p = (v * (4096 - s) * 255) / (64'd4096 * 4096);
        q = (v * (whole - s * f) * 255) / den;
        t = (v * (whole - s * (3840 - f)) * 255) / den;
        case (sec)
          0: begin r8 = top; g8 = t; b8 = p; end
          1: begin r8 = q; g8 = top; b8 = p; end
          2: begin r8 = p; g8 = top; b8 = t; end
          3: begin r8 = p; g8 = q; b8 = top; end
          4: begin r8 = t; g8 = p; b8 = top; end
          default: begin r8 = top; g8 = p; b8 = q; end
        endcase
      end
      res.out_red = 8'(r8);
      res.out_green = 8'(g8);
      res.out_blue = 8'(b8);
    end
    return res;
  endfunction

  function automatic in_t make_pixel(input logic k, input int r, input int g, input int b,
                                     input int h, input int s, input int v);
    in_t px;
    px.kind = k;
    px.red = 8'(r); px.green = 8'(g); px.blue = 8'(b);
    px.hue = 15'(h); px.saturation = 13'(s); px.brightness = 13'(v);
    return px;
  endfunction

  // Directed corners, then random beats. In the random beats, unused fields carry
  // random junk so that every input bit toggles in both directions.
  initial begin
    in_t px;
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 0, 0, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 255, 255, 255, 32767, 8191, 8191));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 128, 128, 128, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 255, 0, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 0, 255, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 0, 0, 255, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 255, 255, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 0, 255, 255, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 255, 0, 255, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 255, 0, 1, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_HSV, 1, 0, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 0, 0, 0));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 255, 255, 255, 0, 0, 4096));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 1000, 0, 2000));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 0, 4096, 4096));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 23039, 4096, 4096));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 23040, 4096, 4096));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 32767, 4096, 4096));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 3840, 4096, 4096));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 11520, 2048, 4096));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 15360, 8191, 8191));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 19200, 4097, 1));
    pending_pixels.push_back(make_pixel(KIND_TO_RGB, 0, 0, 0, 7680, 1, 4096));
    for (int i = 0; i < 1900; i++) begin
      px = in_t'({2'($urandom), $urandom, $urandom});
      px.kind = 1'($urandom_range(1, 0));
      if (px.kind == KIND_TO_RGB && $urandom_range(9, 0) != 0) begin
        // Mostly in-range HSV, with a share of out-of-range noise.
        px.hue = 15'($urandom_range(23039, 0));
        px.saturation = 13'($urandom_range(4096, 0));
        px.brightness = 13'($urandom_range(4096, 0));
      end
      pending_pixels.push_back(px);
    end
    stimulus_done = 1'b1;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: a beat is taken at an edge with start high and busy low. Gaps
  // fall in about a quarter of cycles, except over a stretch of back-to-back beats.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predicted_pixels.push_back(convert_pixel(cmd_i));
        beat_index <= beat_index + 1;
      end
      if (start && busy) begin
        // The current beat has not been taken yet; keep it on the port.
      end else if (pending_pixels.size() != 0 &&
                   ((beat_index > 600 && beat_index < 1000) ||
                    $urandom_range(99, 0) >= 25)) begin
        start <= 1'b1;
        cmd_i <= pending_pixels.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && result_valid_o) begin
      if (predicted_pixels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_o);
        error_count++;
      end else begin
        want = predicted_pixels.pop_front();
        if (result_o.out_red !== want.out_red)
          $display("%0t: out_red expected %0d actual %0d", $time, want.out_red, result_o.out_red);
        if (result_o.out_green !== want.out_green)
          $display("%0t: out_green expected %0d actual %0d", $time, want.out_green,
                   result_o.out_green);
        if (result_o.out_blue !== want.out_blue)
          $display("%0t: out_blue expected %0d actual %0d", $time, want.out_blue,
                   result_o.out_blue);
        if (result_o.out_hue !== want.out_hue)
          $display("%0t: out_hue expected %0d actual %0d", $time, want.out_hue, result_o.out_hue);
        if (result_o.out_saturation !== want.out_saturation)
          $display("%0t: out_saturation expected %0d actual %0d", $time, want.out_saturation,
                   result_o.out_saturation);
        if (result_o.out_brightness !== want.out_brightness)
          $display("%0t: out_brightness expected %0d actual %0d", $time, want.out_brightness,
                   result_o.out_brightness);
        if (result_o !== want) error_count++;
      end
    end
  end

  // End of run: all beats taken and all results back, then a short drain
  // so that a stray extra result would still be seen.
  initial begin
    wait (stimulus_done && pending_pixels.size() == 0);
    @(posedge clk_i);
    while (start || predicted_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("rgb_hsv_color_converter_tb passed");
    end else begin
      $display("rgb_hsv_color_converter_tb failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("rgb_hsv_color_converter_tb failed");
    $finish;
  end

endmodule
